>>> design/qfa_pkg.sv
// shared types and constants for the q-format fixed-point alu
`timescale 1ns / 1ps
package qfa_pkg;
   localparam int DataWidth = 64;
   localparam int DefaultFracBits = 16;
   localparam int QueueDepth = 4;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_ABS = 3'd4,
      OP_LESS = 3'd5,
      OP_GREATER = 3'd6,
      OP_NONE = 3'd7
   } op_type;

   // classified word between front and back
   typedef struct packed {
      op_type op;
      logic [DataWidth-1:0] a;
      logic [DataWidth-1:0] b;
   } work_type;

   // result word
   typedef struct packed {
      logic [DataWidth-1:0] value;
      logic cmp;
      logic err;
   } rsp_type;
endpackage

>>> design/qfa_front.sv
// front: accepts request words into a short queue
`timescale 1ns / 1ps
module qfa_front
   import qfa_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  work_type in_word,
   output logic out_valid,
   input  logic out_ready,
   output work_type out_word
);
   localparam int AW = $clog2(QueueDepth);
   work_type mem_ff [QueueDepth];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready = (cnt_ff != (AW+1)'(QueueDepth));
   assign out_valid = (cnt_ff != '0);
   assign out_word = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   // pointer and count update
   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_word;
   end
endmodule

>>> design/qfa_back.sv
// back: pipelined arithmetic, one word per cycle while the output is not stalled
`timescale 1ns / 1ps
module qfa_back
   import qfa_pkg::*;
#(
   parameter int FracBits = DefaultFracBits
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  work_type in_word,
   output logic out_valid,
   input  logic out_ready,
   output rsp_type out_word
);
   localparam int W = DataWidth;
   localparam int NW = 2 * W;
   // stages: 0 prep/multiply partials, 1..NW divider steps, last output
   localparam int NS = NW + 2;

   logic [NS-1:0] v_ff, v_in;
   logic stall;
   // pipeline payload
   op_type op_ff [NS];
   logic [W-1:0] res_ff [NS];
   logic cmp_ff [NS];
   logic err_ff [NS];
   logic neg_ff [NS];
   logic [NW-1:0] num_ff [NS];
   logic [W-1:0] den_ff [NS];
   logic [W:0] rem_ff [NS];
   logic [W-1:0] quo_ff [NS];
   logic [W-1:0] ll_ff, lh_ff, hl_ff, hh_ff;
   logic [W-1:0] ma_ff, mb_ff;
   logic [W-1:0] mul_ff;

   // output holds when stalled
   assign stall = v_ff[NS-1] && !out_ready;
   assign in_ready = !stall;
   assign out_valid = v_ff[NS-1];
   assign out_word.value = res_ff[NS-1];
   assign out_word.cmp = cmp_ff[NS-1];
   assign out_word.err = err_ff[NS-1];

   always_comb begin
      v_in = {v_ff[NS-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (!stall) v_ff <= v_in;
   end

   // stage 0: classify, simple ops, divider setup, product partials
   logic [W-1:0] a0, b0, maga, magb;
   logic [W-1:0] res0;
   logic cmp0, err0;
   assign a0 = in_word.a;
   assign b0 = in_word.b;
   assign maga = a0[W-1] ? -a0 : a0;
   assign magb = b0[W-1] ? -b0 : b0;

   // simple op results
   always_comb begin
      res0 = '0;
      cmp0 = 1'b0;
      err0 = 1'b0;
      unique case (in_word.op)
         OP_ADD: res0 = a0 + b0;
         OP_SUB: res0 = a0 - b0;
         OP_ABS: res0 = maga;
         OP_LESS: cmp0 = $signed(a0) < $signed(b0);
         OP_GREATER: cmp0 = $signed(a0) > $signed(b0);
         OP_DIV: err0 = (b0 == '0);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         op_ff[0] <= in_word.op;
         cmp_ff[0] <= cmp0;
         err_ff[0] <= err0;
         res_ff[0] <= res0;
         neg_ff[0] <= a0[W-1] ^ b0[W-1];
         num_ff[0] <= {{(NW-W){1'b0}}, maga} << FracBits;
         den_ff[0] <= magb;
         rem_ff[0] <= '0;
         quo_ff[0] <= '0;
         ll_ff <= W'(a0[31:0]) * W'(b0[31:0]);
         lh_ff <= W'(a0[31:0]) * W'(b0[W-1:32]);
         hl_ff <= W'(a0[W-1:32]) * W'(b0[31:0]);
         hh_ff <= W'(a0[W-1:32]) * W'(b0[W-1:32]);
         ma_ff <= a0[W-1] ? b0 : '0;
         mb_ff <= b0[W-1] ? a0 : '0;
      end
   end

   // stage 1: combine product partials with rounding
   logic [NW-1:0] prod, prnd;
   always_comb begin
      prod = {hh_ff, ll_ff} + ({{(W/2){1'b0}}, lh_ff, {(W/2){1'b0}}})
           + ({{(W/2){1'b0}}, hl_ff, {(W/2){1'b0}}});
      prod[NW-1:W] = prod[NW-1:W] - ma_ff - mb_ff;
      prnd = prod + (NW'(1) << (FracBits - 1));
   end
   always_ff @(posedge clock) begin
      if (!stall) mul_ff <= W'(prnd >> FracBits);
   end

   // restoring divider, one quotient bit per stage
   genvar s;
   generate
      for (s = 1; s < NS - 1; s++) begin : g_div
         logic [W:0] r_sh, r_sub;
         assign r_sh = {rem_ff[s-1][W-1:0], num_ff[s-1][NW-1]};
         assign r_sub = r_sh - {1'b0, den_ff[s-1]};
         always_ff @(posedge clock) begin
            if (!stall) begin
               op_ff[s] <= op_ff[s-1];
               res_ff[s] <= res_ff[s-1];
               cmp_ff[s] <= cmp_ff[s-1];
               err_ff[s] <= err_ff[s-1];
               neg_ff[s] <= neg_ff[s-1];
               den_ff[s] <= den_ff[s-1];
               num_ff[s] <= num_ff[s-1] << 1;
               if (!r_sub[W]) begin
                  rem_ff[s] <= r_sub;
                  quo_ff[s] <= {quo_ff[s-1][W-2:0], 1'b1};
               end else begin
                  rem_ff[s] <= r_sh;
                  quo_ff[s] <= {quo_ff[s-1][W-2:0], 1'b0};
               end
            end
         end
      end
   endgenerate

   // multiply result rides a delay line to the output stage
   logic [W-1:0] mdly_ff [NS-3];
   always_ff @(posedge clock) begin
      if (!stall) begin
         mdly_ff[0] <= mul_ff;
         for (int i = 1; i < NS - 3; i++) mdly_ff[i] <= mdly_ff[i-1];
      end
   end

   // final stage: select result
   always_ff @(posedge clock) begin
      if (!stall) begin
         op_ff[NS-1] <= op_ff[NS-2];
         cmp_ff[NS-1] <= cmp_ff[NS-2];
         err_ff[NS-1] <= err_ff[NS-2];
         neg_ff[NS-1] <= neg_ff[NS-2];
         num_ff[NS-1] <= num_ff[NS-2];
         den_ff[NS-1] <= den_ff[NS-2];
         rem_ff[NS-1] <= rem_ff[NS-2];
         quo_ff[NS-1] <= quo_ff[NS-2];
         if (op_ff[NS-2] == OP_MUL) res_ff[NS-1] <= mdly_ff[NS-4];
         else if (op_ff[NS-2] == OP_DIV && !err_ff[NS-2])
            res_ff[NS-1] <= neg_ff[NS-2] ? -quo_ff[NS-2] : quo_ff[NS-2];
         else res_ff[NS-1] <= res_ff[NS-2];
      end
   end
endmodule

>>> design/q_format_fixed_point_alu_unit.sv
// top level of the q-format fixed-point alu
// path from accepted word to result: 1 queue + 2 + 2*64 pipeline stages
// throughput: one word per cycle while the output is not stalled; divide is a fully pipelined bit-per-stage divider
// output stalls freeze the whole pipeline; the input queue accepts until its 4 entries fill
// synchronous active-high reset clears queue pointers and pipeline valid bits
`timescale 1ns / 1ps
module q_format_fixed_point_alu_unit
   import qfa_pkg::*;
#(
   parameter int FracBits = DefaultFracBits
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // req_type[2:0], operand_a[66:3], operand_b[130:67], zero pad to 136
   input  logic [135:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // result_value[63:0], compare_true[64], divide_error[65], zero pad to 72
   output logic [71:0] rsp_tdata
);
   work_type in_w, q_w;
   rsp_type r_w;
   logic q_valid, q_ready;

   assign in_w.op = op_type'(req_tdata[2:0]);
   assign in_w.a = req_tdata[66:3];
   assign in_w.b = req_tdata[130:67];

   qfa_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_word(in_w),
      .out_valid(q_valid), .out_ready(q_ready), .out_word(q_w)
   );

   qfa_back #(.FracBits(FracBits)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_word(q_w),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_word(r_w)
   );

   assign rsp_tdata = {6'b0, r_w.err, r_w.cmp, r_w.value};
endmodule

>>> dv/q_format_fixed_point_alu_unit_tb.sv
// testbench for the q-format fixed-point alu: self-predicting scoreboard with random stalls
`timescale 1ns / 1ps
module q_format_fixed_point_alu_unit_tb;
   import qfa_pkg::*;

   localparam int FracBits = DefaultFracBits;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // req_type[2:0], operand_a[66:3], operand_b[130:67], zero pad to 136
   logic [135:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // result_value[63:0], compare_true[64], divide_error[65], zero pad to 72
   logic [71:0] rsp_tdata;

   int error_count = 0;
   bit stim_done = 1'b0;

   q_format_fixed_point_alu_unit #(.FracBits(FracBits)) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // mismatch report
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // alu predictor and store of expected results
   class alu_scoreboard;
      rsp_type pending[$];

      function rsp_type compute(op_type op, logic [63:0] a, logic [63:0] b);
         rsp_type r;
         logic signed [127:0] prod, num, quo;
         r = '0;
         case (op)
            OP_ADD: r.value = a + b;
            OP_SUB: r.value = a - b;
            OP_MUL: begin
               prod = $signed(a) * $signed(b);
               prod = prod + (128'sd1 <<< (FracBits - 1));
               prod = prod >>> FracBits;
               r.value = prod[63:0];
            end
            OP_DIV: begin
               if (b == 64'd0) r.err = 1'b1;
               else begin
                  num = 128'($signed(a)) <<< FracBits;
                  quo = num / 128'($signed(b));
                  r.value = quo[63:0];
               end
            end
            OP_ABS: r.value = a[63] ? (64'd0 - a) : a;
            OP_LESS: r.cmp = $signed(a) < $signed(b);
            OP_GREATER: r.cmp = $signed(a) > $signed(b);
            default: ;
         endcase
         return r;
      endfunction

      function void note_word(logic [135:0] d);
         pending.push_back(compute(op_type'(d[2:0]), d[66:3], d[130:67]));
      endfunction

      task check_word(logic [71:0] d);
         rsp_type w;
         if (pending.size() == 0) begin
            report_mismatch("unexpected word", d[63:0], 64'd0);
            return;
         end
         w = pending.pop_front();
         if (d[63:0] !== w.value) report_mismatch("result_value", d[63:0], w.value);
         if (d[64] !== w.cmp) report_mismatch("compare_true", 64'(d[64]), 64'(w.cmp));
         if (d[65] !== w.err) report_mismatch("divide_error", 64'(d[65]), 64'(w.err));
         if (d[71:66] !== 6'd0) report_mismatch("pad", 64'(d[71:66]), 64'd0);
      endtask
   endclass

   alu_scoreboard board = new();

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
   endfunction

   function automatic logic [63:0] rand_operand();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: v = 64'h8000_0000_0000_0000;
         1: v = 64'h7fff_ffff_ffff_ffff;
         2: v = 64'd0;
         3: v = {{40{v[63]}}, v[23:0]};
         4: v = {{48{v[63]}}, v[15:0]} << FracBits;
         5: v = (v[0] ? 64'hffff_ffff_ffff_ffff : 64'd1) << $urandom_range(0, 40);
         default: ;
      endcase
      return v;
   endfunction

   // send one word, then maybe idle
   task automatic send_word(input op_type op, input logic [63:0] a, input logic [63:0] b,
                            input bit idle);
      int n;
      req_tdata <= {5'd0, b, a, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_word({5'd0, b, a, op});
      n = idle ? gap_len() : 0;
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // result side: random stalls, check each accepted word
   initial begin
      int n;
      @(negedge reset);
      forever begin
         n = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) board.check_word(rsp_tdata);
      end
   end

   // stimulus
   initial begin
      logic [63:0] mn, mx;
      mn = 64'h8000_0000_0000_0000;
      mx = 64'h7fff_ffff_ffff_ffff;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, every op, divide by zero, abs of min, wraps, unused op
      send_word(OP_ADD, mx, 64'd1, 0);
      send_word(OP_SUB, mn, 64'd1, 0);
      send_word(OP_MUL, mx, mx, 0);
      send_word(OP_MUL, mn, mn, 0);
      send_word(OP_MUL, 64'h0000_0000_0001_8000, 64'hffff_ffff_ffff_8000, 1);
      send_word(OP_MUL, 64'd1, 64'h0000_0000_0000_8000, 0);
      send_word(OP_DIV, mx, 64'd0, 0);
      send_word(OP_DIV, mn, 64'hffff_ffff_ffff_ffff, 0);
      send_word(OP_DIV, mn, mx, 1);
      send_word(OP_DIV, 64'hffff_ffff_ffff_fff9, 64'd2, 0);
      send_word(OP_DIV, 64'd1, mn, 0);
      send_word(OP_ABS, mn, mx, 0);
      send_word(OP_ABS, 64'hffff_ffff_ffff_ffff, 64'd0, 0);
      send_word(OP_LESS, mn, mx, 1);
      send_word(OP_LESS, mx, mn, 0);
      send_word(OP_LESS, 64'd5, 64'd5, 0);
      send_word(OP_GREATER, mx, mn, 0);
      send_word(OP_GREATER, mn, mn, 0);
      send_word(OP_NONE, mx, mx, 1);
      send_word(OP_NONE, mn, mn, 0);
      // random part, with bursts free of idling
      for (int i = 0; i < 650; i++) begin
         send_word(op_type'($urandom_range(0, 7)), rand_operand(), rand_operand(),
                   (i % 200) > 60);
      end
      req_tvalid <= 1'b0;
      stim_done = 1'b1;
   end

   // end of run
   initial begin
      wait (stim_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (error_count == 0 && board.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // timeout
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
